@@ sv/tdmh_pkg.sv @@
// shared types and constants for the timer deadline min-heap
package tdmh_pkg;
  localparam int CAPACITY      = 64;
  localparam int ID_COUNT      = 64;
  localparam int DEADLINE_BITS = 48;
  localparam int SLOT_W  = $clog2(CAPACITY);
  localparam int ID_W    = $clog2(ID_COUNT);
  localparam int COUNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_DUP    = 2'd3;

  typedef struct packed {
    logic [1:0]               command;
    logic [ID_W-1:0]          timer_id;
    logic [DEADLINE_BITS-1:0] deadline;
  } tdmh_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic                     became_top;
    logic [ID_W-1:0]          removed_id;
    logic [ID_W-1:0]          top_id;
    logic [DEADLINE_BITS-1:0] top_deadline;
    logic                     is_empty;
    logic [COUNT_W-1:0]       entry_total;
  } tdmh_out_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DECODE, OP_RD_POS, OP_RD_LAST, OP_START, OP_UP_RD, OP_UP_CMP,
    OP_DN_RD, OP_DN_RD2, OP_DN_CMP, OP_PLACE, OP_TOP_RD, OP_FINISH
  } tdmh_op_t;

  typedef struct packed {
    tdmh_op_t op;
  } tdmh_cmd_t;

  typedef struct packed {
    logic [1:0] decode_status; // status found at decode
    logic       is_add;        // transaction is an add
    logic       no_op;         // transaction leaves the heap alone
    logic       up_go;         // sift up continues
    logic       dn_go;         // sift down continues
    logic       take_up;       // removal moves upward
    logic       no_move;       // removed slot was the last
  } tdmh_stat_t;
endpackage

@@ sv/tdmh_if.sv @@
// valid/ready channel interface
interface tdmh_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ sv/tdmh_datapath.sv @@
// heap storage, back index and sift datapath
module tdmh_datapath (
  input  logic              clk,
  input  logic              rst,
  input  tdmh_pkg::tdmh_in_t  in_item,
  input  tdmh_pkg::tdmh_cmd_t cmd,
  output tdmh_pkg::tdmh_stat_t stat,
  output tdmh_pkg::tdmh_out_t  result
);
  import tdmh_pkg::*;

  logic [ID_W-1:0]          heap_id  [CAPACITY];
  logic [DEADLINE_BITS-1:0] heap_dl  [CAPACITY];
  logic [SLOT_W-1:0]        slot_of  [ID_COUNT];
  logic [ID_COUNT-1:0]      present;
  logic [COUNT_W-1:0]       count;

  tdmh_in_t                 req;
  logic [SLOT_W-1:0]        pos;      // current hole
  logic [SLOT_W-1:0]        nb;       // neighbor slot (parent)
  logic [ID_W-1:0]          mv_id;    // item being placed
  logic [DEADLINE_BITS-1:0] mv_dl;
  logic [ID_W-1:0]          rd_id;    // registered read port a
  logic [DEADLINE_BITS-1:0] rd_dl;
  logic [DEADLINE_BITS-1:0] rd2_dl;   // registered read of right child
  logic [ID_W-1:0]          rd2_id;
  logic [SLOT_W-1:0]        slot_rd;  // registered back index read
  logic                     rc_ok;
  logic [1:0]               status;
  logic [ID_W-1:0]          removed;
  logic                     became;
  logic [SLOT_W-1:0]        rd_addr;
  logic                     wr_en;
  logic [SLOT_W-1:0]        wr_addr;
  logic [ID_W-1:0]          wr_id;
  logic [DEADLINE_BITS-1:0] wr_dl;
  logic [SLOT_W-1:0]        parent;
  logic [COUNT_W:0]         lc_full;
  logic                     lc_ok;
  logic                     use_right;

  assign parent    = SLOT_W'((pos - SLOT_W'(1)) >> 1);
  assign nb        = parent;
  assign lc_full   = {1'b0, pos, 1'b1};
  assign lc_ok     = (COUNT_W+1)'(lc_full) < (COUNT_W+1)'(count);
  assign use_right = rc_ok && (rd_dl > rd2_dl);

  always_comb begin
    stat.decode_status = ST_OK;
    unique case (req.command)
      CMD_ADD: begin
        if (present[req.timer_id]) stat.decode_status = ST_DUP;
        else if (count >= COUNT_W'(CAPACITY)) stat.decode_status = ST_FULL;
      end
      CMD_REMOVE: if (!present[req.timer_id]) stat.decode_status = ST_ABSENT;
      CMD_POP: if (count == '0) stat.decode_status = ST_ABSENT;
      default: stat.decode_status = ST_OK;
    endcase
    stat.is_add  = (req.command == CMD_ADD);
    stat.no_op   = (req.command == CMD_UNUSED);
    stat.up_go   = (pos != '0) && (rd_dl > mv_dl);
    stat.dn_go   = lc_ok && (mv_dl > (use_right ? rd2_dl : rd_dl));
    stat.take_up = (pos != '0) && (rd_dl > mv_dl);
    stat.no_move = ({1'b0, pos} == count);
  end

  always_comb begin
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = pos;
    wr_id = mv_id;
    wr_dl = mv_dl;
    unique case (cmd.op)
      OP_RD_POS:  rd_addr = (req.command == CMD_POP) ? '0 : slot_rd;
      OP_RD_LAST: rd_addr = SLOT_W'(count);
      OP_START, OP_UP_RD: rd_addr = nb;
      OP_DN_RD:   rd_addr = SLOT_W'(lc_full);
      OP_DN_RD2:  rd_addr = SLOT_W'(lc_full + 1'b1);
      OP_UP_CMP: if (stat.up_go) begin
        wr_en = 1'b1; wr_id = rd_id; wr_dl = rd_dl;
      end
      OP_DN_CMP: if (stat.dn_go) begin
        wr_en = 1'b1;
        wr_id = use_right ? rd2_id : rd_id;
        wr_dl = use_right ? rd2_dl : rd_dl;
      end
      OP_PLACE: wr_en = 1'b1;
      default: rd_addr = '0;
    endcase
  end

  // read data and shadow of first read for right child
  always_ff @(posedge clk) begin
    if (cmd.op == OP_DN_RD2) begin
      rd2_id <= heap_id[rd_addr];
      rd2_dl <= heap_dl[rd_addr];
    end else begin
      rd_id <= heap_id[rd_addr];
      rd_dl <= heap_dl[rd_addr];
    end
    slot_rd <= slot_of[req.timer_id];
    if (wr_en) begin
      heap_id[wr_addr] <= wr_id;
      heap_dl[wr_addr] <= wr_dl;
      slot_of[wr_id]   <= wr_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      count   <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          req <= in_item;
          status <= ST_OK; removed <= '0; became <= 1'b0;
        end
        OP_DECODE: status <= stat.decode_status;
        OP_RD_POS: begin
          if (req.command == CMD_ADD) begin
            present[req.timer_id] <= 1'b1;
            pos   <= SLOT_W'(count);
            mv_id <= req.timer_id;
            mv_dl <= req.deadline;
            count <= count + 1'b1;
          end else begin
            pos   <= rd_addr;
            count <= count - 1'b1;
          end
        end
        OP_RD_LAST: begin
          // rd holds the removed slot's entry
          present[rd_id] <= 1'b0;
          removed <= rd_id;
        end
        OP_START: begin
          mv_id <= rd_id;
          mv_dl <= rd_dl;
        end
        OP_UP_CMP: if (stat.up_go) pos <= parent;
        OP_DN_CMP: begin
          rc_ok <= 1'b0;
          if (stat.dn_go) pos <= use_right ? SLOT_W'(lc_full + 1'b1) : SLOT_W'(lc_full);
        end
        OP_DN_RD2: rc_ok <= (COUNT_W+1)'(lc_full + 1'b1) < (COUNT_W+1)'(count);
        OP_PLACE: if (req.command == CMD_ADD) became <= (pos == '0);
        default: ;
      endcase
    end
  end

  assign result.status       = status;
  assign result.became_top   = became;
  assign result.removed_id   = removed;
  assign result.is_empty     = (count == '0);
  assign result.entry_total  = count;
  assign result.top_id       = (count == '0) ? '0 : rd_id;
  assign result.top_deadline = (count == '0) ? '0 : rd_dl;
endmodule

@@ sv/tdmh_ctrl.sv @@
// sequencing state machine
module tdmh_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tdmh_pkg::tdmh_stat_t stat,
  output tdmh_pkg::tdmh_cmd_t  cmd
);
  import tdmh_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_POS = 4'd2, S_LAST = 4'd3,
                         S_CHK = 4'd4, S_START = 4'd5, S_UPRD = 4'd6, S_UPCMP = 4'd7,
                         S_DNRD = 4'd8, S_DNRD2 = 4'd9, S_DNCMP = 4'd10,
                         S_PLACE = 4'd11, S_TOP = 4'd12, S_OUT = 4'd13, S_ADDUP = 4'd14;

  logic [3:0] state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE: begin
        cmd.op = OP_LOAD;
        if (in_valid) state_next = S_DEC;
      end
      S_DEC: begin
        cmd.op = OP_DECODE;
        state_next = (stat.decode_status == ST_OK && !stat.no_op) ? S_POS : S_TOP;
      end
      S_POS: begin
        cmd.op = OP_RD_POS;
        state_next = S_LAST;
      end
      S_LAST: begin
        // for add, go straight into sift up from the new slot
        if (stat.is_add) begin
          cmd.op = OP_UP_RD;
          state_next = S_UPCMP;
        end else begin
          cmd.op = OP_RD_LAST;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        cmd.op = OP_START;
        state_next = stat.no_move ? S_TOP : S_ADDUP;
      end
      S_ADDUP: begin
        cmd.op = OP_UP_RD;
        state_next = stat.take_up ? S_UPCMP : S_DNRD;
      end
      S_UPRD: begin
        cmd.op = OP_UP_RD;
        state_next = S_UPCMP;
      end
      S_UPCMP: begin
        cmd.op = OP_UP_CMP;
        state_next = stat.up_go ? S_UPRD : S_PLACE;
      end
      S_DNRD: begin
        cmd.op = OP_DN_RD;
        state_next = S_DNRD2;
      end
      S_DNRD2: begin
        cmd.op = OP_DN_RD2;
        state_next = S_DNCMP;
      end
      S_DNCMP: begin
        cmd.op = OP_DN_CMP;
        state_next = stat.dn_go ? S_DNRD : S_PLACE;
      end
      S_PLACE: begin
        cmd.op = OP_PLACE;
        state_next = S_START;
      end
      S_START: begin
        cmd.op = OP_TOP_RD;
        state_next = S_TOP;
      end
      S_TOP: begin
        cmd.op = OP_TOP_RD;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

@@ sv/timer_deadline_min_heap_core.sv @@
// top level of the timer deadline min-heap
// One transaction in, one result out. An add places the new entry in the last slot and sifts it up.
// A remove or pop needs no sift when the last slot is freed; else it moves the last entry into
// the freed slot and sifts it up or down, and the heap memory has a single read port.
// Errors and the unused command answer without touching the heap.
// A new transaction is taken only after the previous result has been taken.
module timer_deadline_min_heap_core (
  input logic clk,
  input logic rst,
  tdmh_if.sink   in_ch,
  tdmh_if.source out_ch
);
  import tdmh_pkg::*;

  tdmh_cmd_t  cmd;
  tdmh_stat_t stat;

  tdmh_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  tdmh_datapath u_dp (
    .clk(clk), .rst(rst),
    .in_item(in_ch.payload), .cmd(cmd), .stat(stat), .result(out_ch.payload)
  );
endmodule

@@ tb/tb_timer_deadline_min_heap_core.sv @@
// self-checking testbench for the timer deadline min-heap core
module tb_timer_deadline_min_heap_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tdmh_pkg::*;

  logic clk;
  logic rst;
  tdmh_if #(.T(tdmh_in_t))  in_ch ();
  tdmh_if #(.T(tdmh_out_t)) out_ch ();

  timer_deadline_min_heap_core uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // heap shadow
  logic [ID_W-1:0]    hp_id [CAPACITY];
  logic [47:0]        hp_dl [CAPACITY];
  int                 slot_of [ID_COUNT];
  bit                 present [ID_COUNT];
  int                 count;

  tdmh_out_t expected_q[$];
  int  errors;
  int  cycles;
  bit  hold_off;
  int  hold_len;
  bit  burst_mode;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s got %0h want %0h at cycle %0d", what, got, want, cycles);
  endtask

  function automatic void put(input int pos, input logic [ID_W-1:0] id,
                              input logic [47:0] dl);
    hp_id[pos] = id;
    hp_dl[pos] = dl;
    slot_of[id] = pos;
  endfunction

  function automatic void rise(input int start, input logic [ID_W-1:0] id,
                               input logic [47:0] dl);
    int pos;
    int par;
    pos = start;
    while (pos > 0) begin
      par = (pos - 1) / 2;
      if (hp_dl[par] <= dl) break;
      put(pos, hp_id[par], hp_dl[par]);
      pos = par;
    end
    put(pos, id, dl);
  endfunction

  function automatic void sink_down(input int start, input logic [ID_W-1:0] id,
                                    input logic [47:0] dl);
    int pos;
    int lc;
    int nx;
    pos = start;
    forever begin
      lc = 2 * pos + 1;
      if (lc >= count) break;
      nx = lc;
      if (lc + 1 < count && hp_dl[lc] > hp_dl[lc + 1]) nx = lc + 1;
      if (dl <= hp_dl[nx]) break;
      put(pos, hp_id[nx], hp_dl[nx]);
      pos = nx;
    end
    put(pos, id, dl);
  endfunction

  function automatic void take_out(input int pos);
    int last;
    int par;
    last = count - 1;
    present[hp_id[pos]] = 1'b0;
    count = last;
    if (pos == last) return;
    par = (pos == 0) ? 0 : (pos - 1) / 2;
    if (hp_dl[par] > hp_dl[last]) rise(pos, hp_id[last], hp_dl[last]);
    else sink_down(pos, hp_id[last], hp_dl[last]);
  endfunction

  function automatic tdmh_out_t heap_step(input tdmh_in_t t);
    tdmh_out_t r;
    r = '0;
    r.status = ST_OK;
    if (t.command == CMD_ADD) begin
      if (present[t.timer_id]) r.status = ST_DUP;
      else if (count >= CAPACITY) r.status = ST_FULL;
      else begin
        present[t.timer_id] = 1'b1;
        count++;
        rise(count - 1, t.timer_id, t.deadline);
        r.became_top = (slot_of[t.timer_id] == 0);
      end
    end else if (t.command == CMD_REMOVE) begin
      if (!present[t.timer_id]) r.status = ST_ABSENT;
      else begin
        r.removed_id = t.timer_id;
        take_out(slot_of[t.timer_id]);
      end
    end else if (t.command == CMD_POP) begin
      if (count == 0) r.status = ST_ABSENT;
      else begin
        r.removed_id = hp_id[0];
        take_out(0);
      end
    end
    if (count > 0) begin
      r.top_id = hp_id[0];
      r.top_deadline = hp_dl[0];
    end else r.is_empty = 1'b1;
    r.entry_total = count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic send(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                      input logic [47:0] dl);
    tdmh_in_t t;
    t.command = cmd;
    t.timer_id = id;
    t.deadline = dl;
    in_ch.valid <= 1'b1;
    in_ch.payload <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(heap_step(t));
    @(negedge clk);
    if (burst_mode && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic logic [47:0] rand_dl();
    logic [47:0] d;
    case ($urandom_range(0, 4))
      0: d = '0;
      1: d = '1;
      2: d = 48'($urandom_range(0, 15));
      default: d = 48'({$urandom(), $urandom()});
    endcase
    return d;
  endfunction

  // checker
  always @(posedge clk) begin
    tdmh_out_t got;
    tdmh_out_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (expected_q.size() == 0) report("unexpected transaction", 64'(got.status), 64'(0));
      else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          report("status", 64'(got.status), 64'(want.status));
        if (got.became_top !== want.became_top)
          report("became_top", 64'(got.became_top), 64'(want.became_top));
        if (got.removed_id !== want.removed_id)
          report("removed_id", 64'(got.removed_id), 64'(want.removed_id));
        if (got.top_id !== want.top_id)
          report("top_id", 64'(got.top_id), 64'(want.top_id));
        if (got.top_deadline !== want.top_deadline)
          report("top_deadline", 64'(got.top_deadline), 64'(want.top_deadline));
        if (got.is_empty !== want.is_empty)
          report("is_empty", 64'(got.is_empty), 64'(want.is_empty));
        if (got.entry_total !== want.entry_total)
          report("entry_total", 64'(got.entry_total), 64'(want.entry_total));
      end
    end
  end

  // receiver stall pattern and long hold-off
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if (hold_off) begin
      out_ch.ready <= 1'b0;
      if (hold_len > 0) hold_len <= hold_len - 1;
      else hold_off <= 1'b0;
    end else out_ch.ready <= burst_mode ? (((cycles / 7) % 3 != 0) || $urandom_range(0, 1))
                                        : 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL timer_deadline_min_heap_core");
      $finish;
    end
  end

  task automatic test_directed();
    send(CMD_POP, 6'd0, 48'd0);
    send(CMD_REMOVE, 6'd5, 48'd0);
    send(CMD_ADD, 6'd63, '1);
    send(CMD_ADD, 6'd63, 48'd1);
    send(CMD_ADD, 6'd0, 48'd0);
    send(CMD_ADD, 6'd7, 48'd0);
    send(CMD_ADD, 6'd21, 48'h555555555555);
    send(CMD_ADD, 6'd42, 48'haaaaaaaaaaaa);
    send(CMD_UNUSED, 6'd42, '1);
    send(CMD_REMOVE, 6'd0, 48'd0);
    send(CMD_REMOVE, 6'd0, 48'd0);
    send(CMD_POP, 6'd0, 48'd0);
    send(CMD_POP, 6'd0, 48'd0);
    send(CMD_POP, 6'd0, 48'd0);
    send(CMD_POP, 6'd0, 48'd0);
    send(CMD_POP, 6'd0, 48'd0);
    drain();
  endtask

  task automatic test_fill_full();
    for (int i = 0; i < ID_COUNT; i++) send(CMD_ADD, 6'(i), 48'({$urandom(), $urandom()}));
    send(CMD_ADD, 6'd3, 48'd0);
    for (int i = 0; i < 16; i++) send(CMD_REMOVE, 6'($urandom_range(0, 63)), 48'd0);
    for (int i = 0; i < ID_COUNT; i++) send(CMD_ADD, 6'(i), rand_dl());
    while (count > 0) send(CMD_POP, 6'd0, 48'd0);
    drain();
  endtask

  task automatic test_backpressure();
    hold_len = 300;
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) send(CMD_ADD, 6'($urandom_range(0, 63)), rand_dl());
    drain();
  endtask

  task automatic test_random();
    int r;
    for (int n = 0; n < 1000; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) send(CMD_ADD, 6'($urandom_range(0, 63)), rand_dl());
      else if (r < 70) send(CMD_REMOVE, 6'($urandom_range(0, 63)), rand_dl());
      else if (r < 97) send(CMD_POP, 6'($urandom_range(0, 63)), rand_dl());
      else send(CMD_UNUSED, 6'($urandom_range(0, 63)), rand_dl());
      if (n == 500) drain();
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cycles = 0;
    errors = 0;
    hold_off = 1'b0;
    hold_len = 0;
    burst_mode = 1'b0;
    count = 0;
    for (int i = 0; i < ID_COUNT; i++) begin
      present[i] = 1'b0;
      slot_of[i] = 0;
    end
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    burst_mode = 1'b1;
    test_fill_full();
    test_backpressure();
    test_random();
    if (errors == 0) $display("PASS timer_deadline_min_heap_core");
    else $display("FAIL timer_deadline_min_heap_core");
    $finish;
  end
endmodule
